### src/dsp_pkg.sv
`default_nettype none
package dsp_pkg;
    localparam int NODE_FIELD_BITS   = 8;
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int DIST_BITS         = 23;
    localparam logic [DIST_BITS-1:0] DIST_SAT = 23'h7FFFFF;
    localparam int IN_DATA_BITS      = 2 * NODE_FIELD_BITS + WEIGHT_FIELD_BITS;
    localparam int OUT_DATA_BITS     = 24;
    localparam int OUT_USER_BITS     = 2;
endpackage
`default_nettype wire

### src/dag_shortest_path_topo.sv
`default_nettype none
// edge words load at one per cycle into the adjacency memory while the block is idle
// a word with tlast starts the pass: in-degree, order, relax over n nodes, where
// n = effective node count; the adjacency memory has a single read port
// then a clearing pass over all MAX_NODES*MAX_NODES entries empties the adjacency memory
// reset (synchronous, active low) runs the same clearing pass before the first edge is taken
module dag_shortest_path_topo #(
    parameter int MAX_NODES   = 128,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [7:0]                         i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // edge_from, edge_to, edge_weight
    input  wire logic [dsp_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // distance, zero pad
    output logic [dsp_pkg::OUT_DATA_BITS-1:0]       o_m_tdata,
    // reachable, cycle_error
    output logic [dsp_pkg::OUT_USER_BITS-1:0]       o_m_tuser
);
    import dsp_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int DW = WEIGHT_BITS + IW;
    localparam int EW = (DW > DIST_BITS) ? DW : DIST_BITS;
    localparam int WB = WEIGHT_BITS;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEG  = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_RT   = 4'd5;
    localparam logic [3:0] S_RT2  = 4'd6;
    localparam logic [3:0] S_RLX  = 4'd7;
    localparam logic [3:0] S_RES  = 4'd8;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        f_addr = AW'(a) * AW'(MAX_NODES) + AW'(b);
    endfunction

    logic [WB:0]    r_adj [MAX_NODES*MAX_NODES];
    logic [NW-1:0]  r_deg [MAX_NODES];
    logic [IW-1:0]  r_topo [MAX_NODES];
    logic [DW-1:0]  r_bd [MAX_NODES];

    logic [WB:0]    q_adj;
    logic [NW-1:0]  q_deg;
    logic [IW-1:0]  q_topo;
    logic [DW-1:0]  q_bd;

    logic           adj_we, deg_we, topo_we, bd_we;
    logic [AW-1:0]  adj_raddr, adj_waddr;
    logic [WB:0]    adj_wdata;
    logic [IW-1:0]  deg_raddr, deg_waddr, topo_raddr, topo_waddr, bd_raddr, bd_waddr;
    logic [NW-1:0]  deg_wdata;
    logic [IW-1:0]  topo_wdata;
    logic [DW-1:0]  bd_wdata;

    logic [3:0]           r_st, n_st;
    logic [7:0]           r_nc;
    logic [NW-1:0]        r_col, n_col, r_u, n_u, r_v, n_v, r_k, n_k, r_cnt, n_cnt;
    logic [NW-1:0]        r_pidx, n_pidx;
    logic                 r_pv, n_pv;
    logic [MAX_NODES-1:0] r_placed, n_placed, r_reach, n_reach;
    logic                 r_ru, n_ru, r_cyc, n_cyc;
    logic [DW-1:0]        r_best, n_best, r_d0, n_d0;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_ov, n_ov, r_oreach, n_oreach, r_ocyc, n_ocyc;
    logic [DIST_BITS-1:0] r_odist, n_odist;

    logic [8:0]    ncx, nx;
    logic [NW-1:0] n_eff, nm1;
    logic [7:0]    e_from, e_to;
    logic [WB+WEIGHT_FIELD_BITS-1:0] w_ext;
    logic [WB-1:0] w_in;
    logic          in_range;
    logic          cur_ru;
    logic [DW-1:0] cur_best, bdv, cand;
    logic [DW-1:0] dsel;
    logic [EW-1:0] dx;

    assign ncx   = {1'b0, r_nc};
    assign nx    = (ncx == 9'd0) ? 9'd1 : ((ncx > 9'(MAX_NODES)) ? 9'(MAX_NODES) : ncx);
    assign n_eff = NW'(nx);
    assign nm1   = n_eff - NW'(1);

    assign e_from = i_s_tdata[7:0];
    assign e_to   = i_s_tdata[15:8];
    assign w_ext  = {{WB{1'b0}}, i_s_tdata[31:16]};
    assign w_in   = w_ext[WB-1:0];
    assign in_range = (e_from != 8'd0) && ({1'b0, e_from} <= nx)
                   && (e_to != 8'd0) && ({1'b0, e_to} <= nx);

    assign bdv  = (r_pidx == nm1) ? '0 : q_bd;
    assign cand = bdv + DW'(q_adj[WB-1:0]);
    assign dsel = (nm1 == '0) ? '0 : r_d0;
    assign dx   = EW'(dsel);

    assign o_s_tready = (r_st == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_odist};
    assign o_m_tuser  = {r_ocyc, r_oreach};

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj[adj_waddr] <= adj_wdata;
        end
        q_adj <= r_adj[adj_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            r_deg[deg_waddr] <= deg_wdata;
        end
        q_deg <= r_deg[deg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (topo_we) begin
            r_topo[topo_waddr] <= topo_wdata;
        end
        q_topo <= r_topo[topo_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bd_we) begin
            r_bd[bd_waddr] <= bd_wdata;
        end
        q_bd <= r_bd[bd_raddr];
    end

    always_comb begin
        n_st = r_st;       n_col = r_col;     n_u = r_u;       n_v = r_v;
        n_k = r_k;         n_cnt = r_cnt;     n_pidx = r_pidx; n_pv = 1'b0;
        n_placed = r_placed; n_reach = r_reach;
        n_ru = r_ru;       n_best = r_best;   n_d0 = r_d0;     n_cyc = r_cyc;
        n_clr = r_clr;     n_ov = r_ov;       n_oreach = r_oreach;
        n_ocyc = r_ocyc;   n_odist = r_odist;
        adj_we = 1'b0;  adj_waddr = '0;  adj_wdata = '0;  adj_raddr = '0;
        deg_we = 1'b0;  deg_waddr = '0;  deg_wdata = '0;  deg_raddr = '0;
        topo_we = 1'b0; topo_waddr = '0; topo_wdata = '0; topo_raddr = '0;
        bd_we = 1'b0;   bd_waddr = '0;   bd_wdata = '0;   bd_raddr = '0;
        cur_ru = r_ru;  cur_best = r_best;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_st)
            S_CLR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                if (r_clr == AW'(MAX_NODES * MAX_NODES - 1)) begin
                    n_st = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (in_range) begin
                        adj_we    = 1'b1;
                        adj_waddr = f_addr(IW'(e_from - 8'd1), IW'(e_to - 8'd1));
                        adj_wdata = {1'b1, w_in};
                    end
                    if (i_s_tlast) begin
                        n_col = '0;
                        n_u   = '0;
                        n_cnt = '0;
                        n_cyc = 1'b0;
                        n_st  = S_DEG;
                    end
                end
            end
            S_DEG: begin
                if (r_u < n_eff) begin
                    adj_raddr = f_addr(r_u[IW-1:0], r_col[IW-1:0]);
                    n_u    = r_u + NW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_u;
                end
                if (r_pv) begin
                    if (r_pidx == nm1) begin
                        deg_we    = 1'b1;
                        deg_waddr = r_col[IW-1:0];
                        deg_wdata = r_cnt + NW'(q_adj[WB]);
                        n_cnt = '0;
                        n_u   = '0;
                        if (r_col == nm1) begin
                            n_v      = '0;
                            n_k      = '0;
                            n_placed = '0;
                            n_st     = S_PICK;
                        end else begin
                            n_col = r_col + NW'(1);
                        end
                    end else begin
                        n_cnt = r_cnt + NW'(q_adj[WB]);
                    end
                end
            end
            S_PICK: begin
                if (r_v < n_eff) begin
                    deg_raddr = r_v[IW-1:0];
                    n_v    = r_v + NW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_v;
                end
                if (r_pv) begin
                    if ((q_deg == '0) && !r_placed[r_pidx[IW-1:0]]) begin
                        topo_we    = 1'b1;
                        topo_waddr = r_k[IW-1:0];
                        topo_wdata = r_pidx[IW-1:0];
                        n_placed[r_pidx[IW-1:0]] = 1'b1;
                        n_u  = r_pidx;
                        n_v  = '0;
                        n_pv = 1'b0;
                        n_st = S_DEC;
                    end else if (r_pidx == nm1) begin
                        n_cyc = 1'b1;
                        n_pv  = 1'b0;
                        n_st  = S_RES;
                    end
                end
            end
            S_DEC: begin
                if (r_v < n_eff) begin
                    adj_raddr = f_addr(r_u[IW-1:0], r_v[IW-1:0]);
                    deg_raddr = r_v[IW-1:0];
                    n_v    = r_v + NW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_v;
                end
                if (r_pv) begin
                    if (q_adj[WB] && (q_deg != '0)) begin
                        deg_we    = 1'b1;
                        deg_waddr = r_pidx[IW-1:0];
                        deg_wdata = q_deg - NW'(1);
                    end
                    if (r_pidx == nm1) begin
                        n_v = '0;
                        if (r_k == nm1) begin
                            n_reach = '0;
                            n_reach[nm1[IW-1:0]] = 1'b1;
                            n_k  = nm1;
                            n_st = S_RT;
                        end else begin
                            n_k  = r_k + NW'(1);
                            n_st = S_PICK;
                        end
                    end
                end
            end
            S_RT: begin
                topo_raddr = r_k[IW-1:0];
                n_st = S_RT2;
            end
            S_RT2: begin
                if (NW'(q_topo) == nm1) begin
                    if (r_k == '0) begin
                        n_st = S_RES;
                    end else begin
                        n_k  = r_k - NW'(1);
                        n_st = S_RT;
                    end
                end else begin
                    n_u    = NW'(q_topo);
                    n_v    = '0;
                    n_ru   = 1'b0;
                    n_best = '0;
                    n_st   = S_RLX;
                end
            end
            S_RLX: begin
                if (r_v < n_eff) begin
                    adj_raddr = f_addr(r_u[IW-1:0], r_v[IW-1:0]);
                    bd_raddr  = r_v[IW-1:0];
                    n_v    = r_v + NW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_v;
                end
                if (r_pv) begin
                    if (q_adj[WB] && (q_adj[WB-1:0] != '0) && r_reach[r_pidx[IW-1:0]]
                        && (!r_ru || (cand < r_best))) begin
                        cur_ru   = 1'b1;
                        cur_best = cand;
                    end
                    n_ru   = cur_ru;
                    n_best = cur_best;
                    if (r_pidx == nm1) begin
                        bd_we    = 1'b1;
                        bd_waddr = r_u[IW-1:0];
                        bd_wdata = cur_best;
                        n_reach[r_u[IW-1:0]] = cur_ru;
                        if (r_u == '0) begin
                            n_d0 = cur_best;
                        end
                        if (r_k == '0) begin
                            n_st = S_RES;
                        end else begin
                            n_k  = r_k - NW'(1);
                            n_st = S_RT;
                        end
                    end
                end
            end
            S_RES: begin
                if (!r_ov || i_m_tready) begin
                    n_ov     = 1'b1;
                    n_ocyc   = r_cyc;
                    n_oreach = !r_cyc && r_reach[0];
                    if (!r_cyc && r_reach[0]) begin
                        n_odist = (dx > EW'(DIST_SAT)) ? DIST_SAT : dx[DIST_BITS-1:0];
                    end else begin
                        n_odist = '0;
                    end
                    n_clr = '0;
                    n_st  = S_CLR;
                end
            end
            default: begin
                n_clr = '0;
                n_st  = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
            r_nc  <= 8'd128;
            r_ov  <= 1'b0;
            r_pv  <= 1'b0;
            r_cyc <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_ov  <= n_ov;
            r_pv  <= n_pv;
            r_cyc <= n_cyc;
            if (i_cfg_we) begin
                r_nc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_u      <= n_u;
        r_v      <= n_v;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_pidx   <= n_pidx;
        r_placed <= n_placed;
        r_reach  <= n_reach;
        r_ru     <= n_ru;
        r_best   <= n_best;
        r_d0     <= n_d0;
        r_oreach <= n_oreach;
        r_ocyc   <= n_ocyc;
        r_odist  <= n_odist;
    end
endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
    import dsp_pkg::*;

    localparam int NODES      = 128;
    localparam int CLEAR_WAIT = NODES * NODES + 600;
    localparam int STALL_LIMIT = 400000;
    localparam int EXP_DEPTH  = 64;

    typedef struct packed {
        logic [DIST_BITS-1:0] plen;
        logic                 reach;
        logic                 cyc;
    } path_res_t;

    typedef struct {
        bit        set_cfg;
        logic [7:0] cfg;
        logic [7:0] src;
        logic [7:0] dst;
        logic [15:0] wt;
        bit        last;
        bit        chk;
        path_res_t res;
    } edge_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [7:0]                 i_cfg_wdata;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [IN_DATA_BITS-1:0]    i_s_tdata;
    logic                       i_s_tlast;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [OUT_DATA_BITS-1:0]   o_m_tdata;
    logic [OUT_USER_BITS-1:0]   o_m_tuser;

    dag_shortest_path_topo u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic [15:0] wt_mem [0:NODES*NODES-1];
    bit          link_mem [0:NODES*NODES-1];
    int          node_reg;
    path_res_t   exp_mem [0:EXP_DEPTH-1];
    int          exp_wr;
    int          exp_rd;

    int  mismatches;
    int  burst_left;
    bit  gaps_on;
    bit  hold_rx;
    bit  rand_phase;
    int  idle_cycles = 0;

    function automatic int eff_nodes();
        if (node_reg < 1) return 1;
        if (node_reg > NODES) return NODES;
        return node_reg;
    endfunction

    function automatic path_res_t solve_path();
        int        n;
        int        indeg [NODES];
        bit        placed [NODES];
        int        order [NODES];
        bit        got [NODES];
        longint    best [NODES];
        int        pick;
        int        u;
        bit        cyc;
        longint    cand;
        path_res_t r;
        n = eff_nodes();
        cyc = 0;
        for (int v = 0; v < n; v++) begin
            indeg[v] = 0;
            placed[v] = 0;
        end
        for (int a = 0; a < n; a++)
            for (int v = 0; v < n; v++)
                if (link_mem[a*NODES+v]) indeg[v]++;
        for (int k = 0; k < n; k++) begin
            pick = n;
            for (int v = 0; v < n; v++)
                if (!placed[v] && indeg[v] == 0) begin
                    pick = v;
                    break;
                end
            if (pick == n) begin
                cyc = 1;
                break;
            end
            order[k] = pick;
            placed[pick] = 1;
            for (int v = 0; v < n; v++)
                if (link_mem[pick*NODES+v] && indeg[v] > 0) indeg[v]--;
        end
        r = '0;
        if (cyc) begin
            r.cyc = 1'b1;
        end else begin
            for (int v = 0; v < n; v++) begin
                got[v] = 0;
                best[v] = 0;
            end
            got[n-1] = 1;
            for (int k = n - 1; k >= 0; k--) begin
                u = order[k];
                if (u == n - 1) continue;
                for (int v = 0; v < n; v++)
                    if (link_mem[u*NODES+v] && wt_mem[u*NODES+v] != 0 && got[v]) begin
                        cand = best[v] + wt_mem[u*NODES+v];
                        if (!got[u] || cand < best[u]) begin
                            best[u] = cand;
                            got[u] = 1;
                        end
                    end
            end
            if (got[0]) begin
                r.plen = (best[0] > DIST_SAT) ? DIST_SAT : best[0][DIST_BITS-1:0];
                r.reach = 1'b1;
            end
        end
        for (int i = 0; i < NODES*NODES; i++) link_mem[i] = 0;
        return r;
    endfunction

    task automatic send_edge(input logic [7:0] src, input logic [7:0] dst,
                             input logic [15:0] wt, input bit last,
                             input bit chk, input path_res_t typed);
        int n;
        path_res_t r;
        if (gaps_on && burst_left <= 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {wt, dst, src};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        n = eff_nodes();
        if (src >= 1 && src <= n && dst >= 1 && dst <= n) begin
            wt_mem[(src-1)*NODES + dst - 1] = wt;
            link_mem[(src-1)*NODES + dst - 1] = 1;
        end
        if (last) begin
            r = solve_path();
            exp_mem[exp_wr % EXP_DEPTH] = chk ? typed : r;
            exp_wr++;
        end
    endtask

    task automatic set_nodes(input logic [7:0] val);
        i_s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (CLEAR_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_reg = val;
    endtask

    function automatic logic [7:0] stray_node(input int n);
        if (n >= NODES || $urandom_range(0, 1)) return 8'd0;
        return 8'($urandom_range(n + 1, NODES));
    endfunction

    task automatic send_graph(input int n, input int cnt, input bit loops);
        logic [7:0] src, dst, psrc, pdst;
        int cur;
        int pick;
        cur = 1;
        psrc = 8'd1;
        pdst = 8'd1;
        for (int i = 0; i < cnt; i++) begin
            pick = $urandom_range(0, 99);
            if (n == 1) begin
                src = 8'd1;
                dst = (pick < 10) ? 8'd1 : stray_node(n);
            end else if (pick < 45) begin
                if (cur >= n) cur = $urandom_range(1, n - 1);
                src = 8'(cur);
                dst = 8'($urandom_range(cur + 1, (cur + 8 > n) ? n : cur + 8));
                cur = int'(dst);
            end else if (pick < 80) begin
                src = 8'($urandom_range(1, n - 1));
                dst = 8'($urandom_range(int'(src) + 1, n));
            end else if (pick < 87) begin
                src = psrc;
                dst = pdst;
            end else if (pick < 95) begin
                src = stray_node(n);
                dst = 8'($urandom_range(1, n));
                if (pick[0]) {src, dst} = {dst, src};
            end else if (loops) begin
                dst = 8'($urandom_range(1, n - 1));
                src = 8'($urandom_range(int'(dst), n));
            end else begin
                src = 8'd1;
                dst = 8'(n);
            end
            psrc = src;
            pdst = dst;
            send_edge(src, dst, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom()),
                      i == cnt - 1, 0, '0);
        end
    endtask

    edge_row_t rows [17];

    function automatic edge_row_t mk(input bit sc, input logic [7:0] cfg,
                                     input logic [7:0] src, input logic [7:0] dst,
                                     input logic [15:0] wt, input bit last, input bit chk,
                                     input logic [22:0] d, input bit r, input bit c);
        edge_row_t e;
        e.set_cfg = sc;
        e.cfg = cfg;
        e.src = src;
        e.dst = dst;
        e.wt = wt;
        e.last = last;
        e.chk = chk;
        e.res = '{plen: d, reach: r, cyc: c};
        return e;
    endfunction

    initial begin
        int n;
        int graphs;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        mismatches = 0;
        burst_left = 0;
        gaps_on = 1;
        rand_phase = 0;
        node_reg = NODES;
        exp_wr = 0;
        exp_rd = 0;
        for (int i = 0; i < NODES*NODES; i++) begin
            link_mem[i] = 0;
            wt_mem[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty graph, out of range ends, self loops and cycles, zero weights, reset node count, 0 and 200
        rows[0]  = mk(0, 0,   0,   0,     0, 1, 1, 0, 0, 0);
        rows[1]  = mk(1, 1,   1,   1,     5, 1, 1, 0, 0, 1);
        rows[2]  = mk(0, 0,   0,   5,     7, 1, 1, 0, 1, 0);
        rows[3]  = mk(1, 2,   1,   2, 16'hFFFF, 0, 0, 0, 0, 0);
        rows[4]  = mk(0, 0,   1,   2,     3, 1, 1, 3, 1, 0);
        rows[5]  = mk(0, 0,   1,   2,     0, 1, 1, 0, 0, 0);
        rows[6]  = mk(0, 0,   1,   2,     4, 0, 0, 0, 0, 0);
        rows[7]  = mk(0, 0,   2,   1,     4, 1, 1, 0, 0, 1);
        rows[8]  = mk(0, 0,   3,   1,     9, 0, 0, 0, 0, 0);
        rows[9]  = mk(0, 0,   1,   2, 16'hFFFF, 1, 1, 16'hFFFF, 1, 0);
        rows[10] = mk(1, 128, 128, 0,     1, 0, 0, 0, 0, 0);
        rows[11] = mk(0, 0,   1, 128, 16'hFFFF, 1, 1, 16'hFFFF, 1, 0);
        rows[12] = mk(0, 0,   1,  64,    10, 0, 0, 0, 0, 0);
        rows[13] = mk(0, 0,  64, 128,    20, 0, 0, 0, 0, 0);
        rows[14] = mk(0, 0, 128, 128,     1, 1, 0, 0, 0, 0);
        rows[15] = mk(1, 0,   0,   0,     0, 1, 1, 0, 1, 0);
        rows[16] = mk(1, 200, 1, 128,     5, 1, 1, 5, 1, 0);
        foreach (rows[i]) begin
            if (rows[i].set_cfg) set_nodes(rows[i].cfg);
            send_edge(rows[i].src, rows[i].dst, rows[i].wt, rows[i].last,
                      rows[i].chk, rows[i].res);
        end

        rand_phase = 1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                3:       n = NODES;
                5:       n = $urandom_range(1, 3);
                default: n = $urandom_range(2, 16);
            endcase
            set_nodes(8'(n));
            gaps_on = (ph % 3) != 1;
            graphs = (n == NODES) ? 2 : 7;
            for (int g = 0; g < graphs; g++)
                send_graph(n, $urandom_range(10, 45), $urandom_range(0, 3) == 0);
        end

        i_s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver stall pattern with one long hold-off
    initial begin
        int mode;
        i_m_tready <= 1'b0;
        hold_rx = 0;
        fork
            forever begin
                mode = $urandom_range(0, 3);
                repeat ($urandom_range(50, 400)) begin
                    @(posedge i_clk);
                    if (hold_rx) i_m_tready <= 1'b0;
                    else if (mode == 0) i_m_tready <= 1'b1;
                    else if (mode == 1) i_m_tready <= $urandom_range(0, 1);
                    else i_m_tready <= ($urandom_range(0, 4) == 0);
                end
            end
            begin
                wait (rand_phase);
                repeat (2000) @(posedge i_clk);
                hold_rx = 1;
                repeat (40000) @(posedge i_clk);
                hold_rx = 0;
            end
        join
    end

    // result checker
    always @(posedge i_clk) begin
        path_res_t want;
        path_res_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{plen: o_m_tdata[DIST_BITS-1:0], reach: o_m_tuser[0], cyc: o_m_tuser[1]};
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", got);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("word mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
